/* hdl/itrt_pkg.sv */
// ----------------------------------------------------------------------------
// itrt_pkg: shared constants, types and helpers for the radix text converter
// Holds default sizes, ASCII codes, the radix limits and the job descriptor
// that travels from the front part to the back part.
// ----------------------------------------------------------------------------
package itrt_pkg;

  // Default sizes
  localparam int VALUE_WIDTH = 32;
  localparam int DIV_STEPS   = 8;   // quotient bits resolved per cycle
  localparam int MID_DEPTH   = 2;   // job queue between front and back
  localparam int OUT_DEPTH   = 4;   // result queue in front of the output

  localparam int RADIX_W = 6;
  localparam int CHAR_W  = 7;

  // Radix register
  localparam logic [RADIX_W-1:0] RADIX_RESET   = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN     = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX     = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_DECIMAL = 6'd10;

  // ASCII codes
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_LOW_A = 7'h61;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;

  localparam logic [RADIX_W-1:0] DIGIT_MAX = 6'd9;
  localparam logic [CHAR_W-1:0]  DIGIT_TEN = 7'd10;

  // Control part of one job
  typedef struct packed {
    logic               neg;   // emit a leading minus sign
    logic [RADIX_W-1:0] base;  // saturated radix, 2..36
  } job_ctl_t;

  // Map a digit value to its lower-case ASCII character
  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] dw;
    dw = CHAR_W'(d);
    if (d > DIGIT_MAX) begin
      return dw - DIGIT_TEN + CHAR_LOW_A;
    end
    return dw + CHAR_ZERO;
  endfunction

endpackage

/* hdl/itrt_ram.sv */
// ----------------------------------------------------------------------------
// itrt_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module itrt_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = itrt_pkg::VALUE_WIDTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/itrt_fifo.sv */
// ----------------------------------------------------------------------------
// itrt_fifo: small register queue
// Push/pop queue with full, empty and an occupancy count.
// ----------------------------------------------------------------------------
module itrt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = itrt_pkg::OUT_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wr_data,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rd_data,
  output logic                       full,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign count   = count_r;
  assign rd_data = mem[rd_ptr_r];
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed item
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* hdl/itrt_front.sv */
// ----------------------------------------------------------------------------
// itrt_front: input side of the converter
// Holds the radix register, saturates it, and turns each accepted value into
// a job: a magnitude plus sign and base for the back part.
// ----------------------------------------------------------------------------
module itrt_front #(
  parameter int VALUE_WIDTH = itrt_pkg::VALUE_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [itrt_pkg::RADIX_W-1:0]   cfg_radix,
  input  logic                           in_push,
  input  logic [VALUE_WIDTH-1:0]         in_value,
  output logic                           in_full,
  input  logic                           job_full,
  output logic                           job_push,
  output logic [VALUE_WIDTH-1:0]         job_mag,
  output itrt_pkg::job_ctl_t             job_ctl
);

  logic [itrt_pkg::RADIX_W-1:0] radix_r;
  logic [itrt_pkg::RADIX_W-1:0] base;
  logic                         neg;

  // Radix register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= itrt_pkg::RADIX_RESET;
    end else if (cfg_we) begin
      radix_r <= cfg_radix;
    end
  end

  // Clamp the radix into its legal range
  always_comb begin
    if (radix_r < itrt_pkg::RADIX_MIN) begin
      base = itrt_pkg::RADIX_MIN;
    end else if (radix_r > itrt_pkg::RADIX_MAX) begin
      base = itrt_pkg::RADIX_MAX;
    end else begin
      base = radix_r;
    end
  end

  // Classify: only decimal output is signed
  assign neg          = (base == itrt_pkg::RADIX_DECIMAL) & in_value[VALUE_WIDTH-1];
  assign job_mag      = neg ? (~in_value + 1'b1) : in_value;
  assign job_ctl.neg  = neg;
  assign job_ctl.base = base;
  assign job_push     = in_push & ~job_full;
  assign in_full      = job_full;

endmodule

/* hdl/itrt_back.sv */
// ----------------------------------------------------------------------------
// itrt_back: digit generator and character emitter
// Divides the magnitude by the radix a few bits per cycle, stores each digit,
// then reads the digits back most significant first into the result queue.
// ----------------------------------------------------------------------------
module itrt_back #(
  parameter int VALUE_WIDTH = itrt_pkg::VALUE_WIDTH,
  parameter int DIV_STEPS   = itrt_pkg::DIV_STEPS,
  parameter int OUT_DEPTH   = itrt_pkg::OUT_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             job_valid,
  output logic                             job_pop,
  input  logic [VALUE_WIDTH-1:0]           job_mag,
  input  itrt_pkg::job_ctl_t               job_ctl,
  input  logic [$clog2(OUT_DEPTH+1)-1:0]   res_count,
  output logic                             res_push,
  output logic [itrt_pkg::CHAR_W:0]        res_data
);

  localparam int RW     = itrt_pkg::RADIX_W;
  localparam int CHUNKS = (VALUE_WIDTH + DIV_STEPS - 1) / DIV_STEPS;
  localparam int PW     = CHUNKS * DIV_STEPS;
  localparam int CHK_W  = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int CNT_W  = $clog2(VALUE_WIDTH + 1);
  localparam int IDX_W  = $clog2(VALUE_WIDTH);
  localparam int OCW    = $clog2(OUT_DEPTH + 1) + 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [PW-1:0]    quo_r, quo_nxt;
  logic [RW-1:0]    rem_r, rem_nxt;
  logic [RW-1:0]    base_r;
  logic             neg_r;
  logic [CHK_W-1:0] chunk_r, chunk_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             sign_pend_r, sign_pend_nxt;
  logic             rd_vld_r;
  logic             rd_last_r;

  logic [DIV_STEPS-1:0] top_bits;
  logic [DIV_STEPS-1:0] qbits;
  logic [PW-1:0]        quo_shift;
  logic                 last_chunk;
  logic                 digit_we;
  logic                 space;
  logic                 sign_fire;
  logic                 rd_fire;
  logic [CNT_W-1:0]     cnt_dec;
  logic [RW-1:0]        rd_digit;

  // Resolve DIV_STEPS quotient bits by restoring division
  always_comb begin
    logic [RW:0] r;
    r        = {1'b0, rem_r};
    qbits    = '0;
    top_bits = quo_r[PW-1 -: DIV_STEPS];
    for (int s = DIV_STEPS - 1; s >= 0; s--) begin
      r = {r[RW-1:0], top_bits[s]};
      if (r >= {1'b0, base_r}) begin
        r        = r - {1'b0, base_r};
        qbits[s] = 1'b1;
      end
    end
    rem_nxt   = r[RW-1:0];
    quo_shift = PW'({quo_r, qbits});
  end

  assign last_chunk = (chunk_r == CHK_W'(CHUNKS - 1));
  assign digit_we   = (state_r == ST_DIV) & last_chunk;
  assign cnt_dec    = cnt_r - 1'b1;

  // Emit only while the result queue has room for what is in flight
  assign space     = (OCW'(res_count) + OCW'(rd_vld_r)) < OCW'(OUT_DEPTH);
  assign sign_fire = (state_r == ST_EMIT) & sign_pend_r & space;
  assign rd_fire   = (state_r == ST_EMIT) & ~sign_pend_r & space;
  assign job_pop   = (state_r == ST_IDLE) & job_valid;

  // Sequence: load, divide digit by digit, emit
  always_comb begin
    state_nxt     = state_r;
    quo_nxt       = quo_r;
    chunk_nxt     = chunk_r;
    cnt_nxt       = cnt_r;
    sign_pend_nxt = sign_pend_r;
    unique case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          quo_nxt   = PW'(job_mag);
          chunk_nxt = '0;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        quo_nxt = quo_shift;
        if (last_chunk) begin
          chunk_nxt = '0;
          cnt_nxt   = cnt_r + 1'b1;
          if (quo_shift == '0) begin
            sign_pend_nxt = neg_r;
            state_nxt     = ST_EMIT;
          end
        end else begin
          chunk_nxt = chunk_r + 1'b1;
        end
      end
      ST_EMIT: begin
        if (sign_fire) begin
          sign_pend_nxt = 1'b0;
        end
        if (rd_fire) begin
          cnt_nxt = cnt_dec;
          if (cnt_r == CNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      chunk_r     <= '0;
      cnt_r       <= '0;
      sign_pend_r <= 1'b0;
      rd_vld_r    <= 1'b0;
      quo_r       <= '0;
      neg_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chunk_r     <= chunk_nxt;
      cnt_r       <= cnt_nxt;
      sign_pend_r <= sign_pend_nxt;
      rd_vld_r    <= rd_fire;
      quo_r       <= quo_nxt;
      if (job_pop) begin
        neg_r <= job_ctl.neg;
      end
    end
  end

  // Hold the base and the running remainder
  always_ff @(posedge clk) begin
    if (job_pop) begin
      base_r <= job_ctl.base;
      rem_r  <= '0;
    end else if (state_r == ST_DIV) begin
      rem_r <= last_chunk ? '0 : rem_nxt;
    end
    if (rd_fire) begin
      rd_last_r <= (cnt_r == CNT_W'(1));
    end
  end

  // Digit store, least significant digit at address zero
  itrt_ram #(
    .WIDTH (RW),
    .DEPTH (VALUE_WIDTH)
  ) u_digits (
    .clk   (clk),
    .we    (digit_we),
    .waddr (cnt_r[IDX_W-1:0]),
    .wdata (rem_nxt),
    .re    (rd_fire),
    .raddr (cnt_dec[IDX_W-1:0]),
    .rdata (rd_digit)
  );

  // Push the sign or the digit that just came out of the store
  assign res_push = sign_fire | rd_vld_r;
  assign res_data = rd_vld_r ? {rd_last_r, itrt_pkg::digit_char(rd_digit)}
                             : {1'b0, itrt_pkg::CHAR_MINUS};

endmodule

/* hdl/integer_to_radix_text_core.sv */
// ----------------------------------------------------------------------------
// integer_to_radix_text_core: signed integer to ASCII text in radix 2..36
// The back part converts one value at a time, digits then characters; the job
// queue lets further values be accepted while it is busy. A minus sign, when
// present, is the first character of the text.
// Reset: synchronous, radix returns to ten, all queues empty, no clearing pass.
// ----------------------------------------------------------------------------
module integer_to_radix_text_core #(
  parameter int VALUE_WIDTH = itrt_pkg::VALUE_WIDTH,
  parameter int DIV_STEPS   = itrt_pkg::DIV_STEPS,
  parameter int MID_DEPTH   = itrt_pkg::MID_DEPTH,
  parameter int OUT_DEPTH   = itrt_pkg::OUT_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [itrt_pkg::RADIX_W-1:0] cfg_radix,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic [VALUE_WIDTH-1:0]       in_value,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic [itrt_pkg::CHAR_W-1:0]  out_character,
  output logic                         out_last_char
);

  localparam int CTL_W = $bits(itrt_pkg::job_ctl_t);
  localparam int JOB_W = VALUE_WIDTH + CTL_W;
  localparam int RES_W = itrt_pkg::CHAR_W + 1;

  logic                           job_push, job_full, job_empty, job_pop;
  logic [VALUE_WIDTH-1:0]         front_mag, back_mag;
  itrt_pkg::job_ctl_t             front_ctl, back_ctl;
  logic [JOB_W-1:0]               job_rd;
  logic [$clog2(MID_DEPTH+1)-1:0] job_count;
  logic                           res_push, res_full;
  logic [RES_W-1:0]               res_wr, res_rd;
  logic [$clog2(OUT_DEPTH+1)-1:0] res_count;

  // Front: radix register and item classification
  itrt_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_radix (cfg_radix),
    .in_push   (in_push),
    .in_value  (in_value),
    .in_full   (in_full),
    .job_full  (job_full),
    .job_push  (job_push),
    .job_mag   (front_mag),
    .job_ctl   (front_ctl)
  );

  // Job queue between the two parts
  itrt_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (MID_DEPTH)
  ) u_job_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (job_push),
    .wr_data ({front_ctl, front_mag}),
    .pop     (job_pop),
    .rd_data (job_rd),
    .full    (job_full),
    .empty   (job_empty),
    .count   (job_count)
  );

  assign back_mag = job_rd[VALUE_WIDTH-1:0];
  assign back_ctl = itrt_pkg::job_ctl_t'(job_rd[JOB_W-1:VALUE_WIDTH]);

  // Back: digit division and character emission
  itrt_back #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .DIV_STEPS   (DIV_STEPS),
    .OUT_DEPTH   (OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (~job_empty),
    .job_pop   (job_pop),
    .job_mag   (back_mag),
    .job_ctl   (back_ctl),
    .res_count (res_count),
    .res_push  (res_push),
    .res_data  (res_wr)
  );

  // Result queue toward the consumer
  itrt_fifo #(
    .WIDTH (RES_W),
    .DEPTH (OUT_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res_wr),
    .pop     (out_pop),
    .rd_data (res_rd),
    .full    (res_full),
    .empty   (out_empty),
    .count   (res_count)
  );

  assign out_character = res_rd[itrt_pkg::CHAR_W-1:0];
  assign out_last_char = res_rd[RES_W-1] & ~res_full | res_rd[RES_W-1] & res_full;
  // job_count is unused beyond occupancy tracking inside the queue
  logic unused_job_count;
  assign unused_job_count = |job_count;

endmodule
